// ===== rtl/csma_pkg.sv =====
// shared types and constants of the command source mode arbiter
`default_nettype none

package csma_pkg;

  localparam int FIELD_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // event kinds on the input channel
  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_TWIST = 3'd1;
  localparam logic [2:0] OP_HELM = 3'd2;
  localparam logic [2:0] OP_COURSE = 3'd3;
  localparam logic [2:0] OP_WRENCH = 3'd4;
  localparam logic [2:0] OP_ODOM = 3'd5;

  // command kinds held in the recency list
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_TWIST = 2'd0;
  localparam kind_t KIND_HELM = 2'd1;
  localparam kind_t KIND_COURSE = 2'd2;
  localparam kind_t KIND_WRENCH = 2'd3;

  // newest first
  typedef kind_t [3:0] order_t;

  // drive modes
  localparam logic [2:0] MODE_NONE = 3'd0;
  localparam logic [2:0] MODE_TWIST = 3'd1;
  localparam logic [2:0] MODE_TWIST_LIN = 3'd2;
  localparam logic [2:0] MODE_COURSE = 3'd3;
  localparam logic [2:0] MODE_HELM = 3'd4;
  localparam logic [2:0] MODE_WRENCH = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_TIMEOUT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_COV_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_COV_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLE = 3'd4;

  // register reset values
  localparam logic [FIELD_W-1:0] HEADING_TIMEOUT_RST = 16'd10;
  localparam logic [FIELD_W-1:0] VELOCITY_TIMEOUT_RST = 16'd10;
  localparam logic [FIELD_W-1:0] VELOCITY_COV_LIMIT_RST = 16'd72;
  localparam logic [FIELD_W-1:0] HEADING_COV_LIMIT_RST = 16'd256;

  typedef struct packed {
    logic [2:0]         op;
    logic [FIELD_W-1:0] vel_cov_x;
    logic [FIELD_W-1:0] vel_cov_y;
    logic [FIELD_W-1:0] yaw_pose_cov;
    logic [FIELD_W-1:0] yaw_rate_cov;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       heading_timed_out;
    logic       velocity_timed_out;
    logic       zero_drive;
    logic       publish_drive;
  } out_beat_t;

  // what the mode selector needs to see
  typedef struct packed {
    order_t     order;
    logic [3:0] seen;
    logic       hto;
    logic       vto;
  } sel_in_t;

endpackage

`default_nettype wire

// ===== rtl/csma_cov_qual.sv =====
// covariance pair check against a limit, saturated to the datapath width
`default_nettype none

module csma_cov_qual #(
  parameter int COV_WIDTH = 16
) (
  input  wire logic [csma_pkg::FIELD_W-1:0] cov_a,
  input  wire logic [csma_pkg::FIELD_W-1:0] cov_b,
  input  wire logic [csma_pkg::FIELD_W-1:0] limit,
  output logic                              ok
);

  logic [COV_WIDTH-1:0] a_sat;
  logic [COV_WIDTH-1:0] b_sat;
  logic [COV_WIDTH-1:0] lim_sat;

  generate
    if (COV_WIDTH >= csma_pkg::FIELD_W) begin : g_wide
      assign a_sat = COV_WIDTH'(cov_a);
      assign b_sat = COV_WIDTH'(cov_b);
      assign lim_sat = COV_WIDTH'(limit);
    end else begin : g_narrow
      // clamp anything above the narrow range to its top value
      assign a_sat = (|cov_a[csma_pkg::FIELD_W-1:COV_WIDTH]) ? '1 : cov_a[COV_WIDTH-1:0];
      assign b_sat = (|cov_b[csma_pkg::FIELD_W-1:COV_WIDTH]) ? '1 : cov_b[COV_WIDTH-1:0];
      assign lim_sat = (|limit[csma_pkg::FIELD_W-1:COV_WIDTH]) ? '1 : limit[COV_WIDTH-1:0];
    end
  endgenerate

  // strictly below, equal does not qualify
  assign ok = (a_sat < lim_sat) && (b_sat < lim_sat);

endmodule

`default_nettype wire

// ===== rtl/csma_mode_sel.sv =====
// picks the drive mode from the newest eligible command
`default_nettype none

module csma_mode_sel (
  input  wire csma_pkg::sel_in_t sel,
  output logic [2:0]             mode
);

  logic [3:0] eligible;

  always_comb begin
    eligible = 4'b0;
    eligible[csma_pkg::KIND_WRENCH] = 1'b1;
    eligible[csma_pkg::KIND_TWIST] = !sel.hto;
    eligible[csma_pkg::KIND_HELM] = !sel.hto;
    eligible[csma_pkg::KIND_COURSE] = !sel.hto && !sel.vto;
    eligible = eligible & sel.seen;
  end

  // walk oldest to newest so the newest hit is left standing
  always_comb begin
    mode = csma_pkg::MODE_NONE;
    for (int i = 3; i >= 0; i--) begin
      if (eligible[sel.order[i]]) begin
        case (sel.order[i])
          csma_pkg::KIND_TWIST:  mode = sel.vto ? csma_pkg::MODE_TWIST_LIN : csma_pkg::MODE_TWIST;
          csma_pkg::KIND_HELM:   mode = csma_pkg::MODE_HELM;
          csma_pkg::KIND_COURSE: mode = csma_pkg::MODE_COURSE;
          default:               mode = csma_pkg::MODE_WRENCH;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/command_source_mode_arbiter.sv =====
// top level of the command source mode arbiter
// Takes one event beat per clock while in_stall is low: a control tick, a
// twist, helm, course or wrench command, or an odometry report. Every event
// is retired in a single pass from the input register, so the block sustains
// one beat per cycle unless a stalled tick is held there. A tick's result
// beat is registered in the input register and then in the output register
// before it can be taken. Only ticks produce a result beat
// (mode, timeout flags, zero and publish flags); all other events just update
// the sensor ages or the command recency list. When the output register is
// full and stalled, a waiting tick holds in the input register and in_stall
// rises; command and odometry beats keep retiring regardless. Both sensor
// ages come out of reset saturated, so both sensors start timed out, and no
// command has been seen, so the first ticks report mode none. Registers may
// be written at any cycle the block is idle and take effect on the next beat.
`default_nettype none

module command_source_mode_arbiter #(
  parameter int AGE_WIDTH = 16,
  parameter int COV_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire csma_pkg::in_beat_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output csma_pkg::out_beat_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [csma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [csma_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // compare width for age against a 16 bit timeout
  localparam int CMP_W = (AGE_WIDTH > csma_pkg::FIELD_W) ? AGE_WIDTH : csma_pkg::FIELD_W;

  // configuration registers
  logic [csma_pkg::FIELD_W-1:0] heading_timeout;
  logic [csma_pkg::FIELD_W-1:0] velocity_timeout;
  logic [csma_pkg::FIELD_W-1:0] velocity_cov_limit;
  logic [csma_pkg::FIELD_W-1:0] heading_cov_limit;
  logic                         drive_enable;

  // input register
  logic               s1_valid;
  csma_pkg::in_beat_t s1;

  // arbiter state
  logic [AGE_WIDTH-1:0] heading_age;
  logic [AGE_WIDTH-1:0] velocity_age;
  logic [AGE_WIDTH-1:0] heading_age_next;
  logic [AGE_WIDTH-1:0] velocity_age_next;
  csma_pkg::order_t     order;
  csma_pkg::order_t     order_next;
  logic [3:0]           seen;
  logic [3:0]           seen_next;

  logic                 s1_tick;
  logic                 s1_go;
  logic                 proc;
  logic                 vel_ok;
  logic                 head_ok;
  logic                 hto;
  logic                 vto;
  logic [AGE_WIDTH-1:0] heading_inc;
  logic [AGE_WIDTH-1:0] velocity_inc;
  csma_pkg::kind_t      cmd_kind;
  logic                 is_cmd;
  logic [1:0]           hit_pos;
  csma_pkg::sel_in_t    sel;
  logic [2:0]           mode;
  csma_pkg::out_beat_t  result;

  // ---------------------------------------------------------------------
  // configuration writes, out of range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_timeout <= csma_pkg::HEADING_TIMEOUT_RST;
      velocity_timeout <= csma_pkg::VELOCITY_TIMEOUT_RST;
      velocity_cov_limit <= csma_pkg::VELOCITY_COV_LIMIT_RST;
      heading_cov_limit <= csma_pkg::HEADING_COV_LIMIT_RST;
      drive_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csma_pkg::REG_HEADING_TIMEOUT:    heading_timeout <= cfg_data;
        csma_pkg::REG_VELOCITY_TIMEOUT:   velocity_timeout <= cfg_data;
        csma_pkg::REG_VELOCITY_COV_LIMIT: velocity_cov_limit <= cfg_data;
        csma_pkg::REG_HEADING_COV_LIMIT:  heading_cov_limit <= cfg_data;
        csma_pkg::REG_DRIVE_ENABLE:       drive_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // flow control: only a tick needs room in the output register
  assign s1_tick = (s1.op == csma_pkg::OP_TICK);
  assign s1_go = !(s1_tick && out_valid && out_stall);
  assign proc = s1_valid && s1_go;
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  // ---------------------------------------------------------------------
  // odometry qualification
  csma_cov_qual #(
    .COV_WIDTH(COV_WIDTH)
  ) u_vel_qual (
    .cov_a(s1.vel_cov_x),
    .cov_b(s1.vel_cov_y),
    .limit(velocity_cov_limit),
    .ok   (vel_ok)
  );

  csma_cov_qual #(
    .COV_WIDTH(COV_WIDTH)
  ) u_head_qual (
    .cov_a(s1.yaw_pose_cov),
    .cov_b(s1.yaw_rate_cov),
    .limit(heading_cov_limit),
    .ok   (head_ok)
  );

  // saturating age step
  assign heading_inc = (&heading_age) ? heading_age : heading_age + AGE_WIDTH'(1);
  assign velocity_inc = (&velocity_age) ? velocity_age : velocity_age + AGE_WIDTH'(1);

  // timeouts see the stepped ages
  assign hto = CMP_W'(heading_inc) > CMP_W'(heading_timeout);
  assign vto = CMP_W'(velocity_inc) > CMP_W'(velocity_timeout);

  always_comb begin
    heading_age_next = heading_age;
    velocity_age_next = velocity_age;
    if (proc && s1_tick) begin
      heading_age_next = heading_inc;
      velocity_age_next = velocity_inc;
    end else if (proc && s1.op == csma_pkg::OP_ODOM) begin
      if (head_ok) heading_age_next = '0;
      if (vel_ok) velocity_age_next = '0;
    end
  end

  // ---------------------------------------------------------------------
  // command recency list: move the new kind to the front
  always_comb begin
    is_cmd = 1'b0;
    cmd_kind = csma_pkg::KIND_TWIST;
    case (s1.op) inside
      csma_pkg::OP_TWIST, csma_pkg::OP_HELM, csma_pkg::OP_COURSE, csma_pkg::OP_WRENCH: begin
        is_cmd = 1'b1;
        cmd_kind = 2'(s1.op - csma_pkg::OP_TWIST);
      end
      default: ;
    endcase
  end

  always_comb begin
    hit_pos = 2'd3;
    for (int i = 3; i >= 0; i--) begin
      if (order[i] == cmd_kind) hit_pos = 2'(i);
    end
  end

  always_comb begin
    order_next = order;
    seen_next = seen;
    if (proc && is_cmd) begin
      for (int i = 1; i < 4; i++) begin
        if (2'(i) <= hit_pos) order_next[i] = order[i-1];
      end
      order_next[0] = cmd_kind;
      seen_next[cmd_kind] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_age <= '1;
      velocity_age <= '1;
      order <= {csma_pkg::KIND_WRENCH, csma_pkg::KIND_COURSE,
                csma_pkg::KIND_HELM, csma_pkg::KIND_TWIST};
      seen <= 4'b0;
    end else begin
      heading_age <= heading_age_next;
      velocity_age <= velocity_age_next;
      order <= order_next;
      seen <= seen_next;
    end
  end

  // ---------------------------------------------------------------------
  // mode selection on a tick
  assign sel.order = order;
  assign sel.seen = seen;
  assign sel.hto = hto;
  assign sel.vto = vto;

  csma_mode_sel u_mode_sel (
    .sel (sel),
    .mode(mode)
  );

  assign result.mode = mode;
  assign result.heading_timed_out = hto;
  assign result.velocity_timed_out = vto;
  assign result.zero_drive = (mode == csma_pkg::MODE_NONE);
  assign result.publish_drive = drive_enable && (mode != csma_pkg::MODE_NONE);

  // ---------------------------------------------------------------------
  // output register, one result beat per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (proc && s1_tick) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_tick) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire
